### src/rfd_pkg.sv
// Package for the response frame deframer.
// Holds the frame phase and status codes and the result record type.
// No dependencies.
package rfd_pkg;

   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] PAD_BYTE   = 8'h00;
   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd255;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_LCS  = 3'd2,
      PH_DATA = 3'd3,
      PH_DCS  = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_START = 3'd1,
      ST_NO_DATA  = 3'd2,
      ST_LEN_CS   = 3'd3,
      ST_DATA_CS  = 3'd4,
      ST_TOO_LONG = 3'd5
   } status_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] payload_byte;
      status_type status;
      logic [7:0] frame_length;
   } rsp_type;

endpackage

### src/response_frame_deframer.sv
// Response frame deframer top level: frame parser, result register and skid entry.
// Depends on rfd_pkg for phase and status codes and the result record.

// The block takes one received byte per item and handles one item in every clock
// cycle while req_stall is low: the frame parser is a single pass of compares and
// an 8-bit add from the accepted byte and the frame state to the result register.
// Payload bytes come out as they arrive, and each frame ends with exactly one
// status item. The output side has a result register plus one skid entry. The skid
// entry fills only when a new result arrives while rsp_stall holds a full result
// register, and req_stall is high exactly while the skid entry is occupied, so it
// falls in the cycle after rsp_stall lets the result register drain. csr_wr_data
// sets the largest accepted payload length (reset 255); the user must write it only
// while the block is idle, and the block itself does not enforce this.
module response_frame_deframer
   import rfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_window_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_status,
   output logic [7:0] rsp_payload_byte,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_frame_length
);

   logic [7:0] max_payload_ff;
   phase_type  phase_ff, phase_in;
   logic [7:0] decl_len_ff, decl_len_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_ff, sum_in;

   logic       res_valid;
   rsp_type    res;

   logic       out_valid_ff;
   rsp_type    out_ff;
   logic       skid_valid_ff;
   rsp_type    skid_ff;

   logic       req_accept;
   logic       out_drain;
   logic [7:0] len_check;
   logic [7:0] data_check;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_drain  = out_valid_ff && !rsp_stall;
   assign len_check  = decl_len_ff + req_rx_byte;
   assign data_check = sum_ff + req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         decl_len_ff   <= '0;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         decl_len_ff   <= decl_len_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      decl_len_in        = decl_len_ff;
      bytes_left_in      = bytes_left_ff;
      sum_in             = sum_ff;
      res_valid          = 1'b0;
      res.is_status      = 1'b1;
      res.payload_byte   = '0;
      res.status         = ST_OK;
      res.frame_length   = '0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (req_rx_byte == START_BYTE) begin
               phase_in = PH_LEN;
            end else if (req_rx_byte != PAD_BYTE) begin
               res_valid  = 1'b1;
               res.status = ST_NO_START;
               phase_in   = PH_DONE;
            end
         end
         PH_LEN: begin
            decl_len_in = req_rx_byte;
            phase_in    = PH_LCS;
         end
         PH_LCS: begin
            // The length checksum is tested before the length limit.
            if (len_check != 8'd0) begin
               res_valid  = 1'b1;
               res.status = ST_LEN_CS;
               phase_in   = PH_DONE;
            end else if (decl_len_ff > max_payload_ff) begin
               res_valid  = 1'b1;
               res.status = ST_TOO_LONG;
               phase_in   = PH_DONE;
            end else begin
               bytes_left_in = decl_len_ff;
               sum_in        = '0;
               phase_in      = (decl_len_ff == 8'd0) ? PH_DCS : PH_DATA;
            end
         end
         PH_DATA: begin
            sum_in           = data_check;
            res_valid        = 1'b1;
            res.is_status    = 1'b0;
            res.payload_byte = req_rx_byte;
            bytes_left_in    = bytes_left_ff - 8'd1;
            if (bytes_left_ff <= 8'd1) begin
               phase_in = PH_DCS;
            end
         end
         PH_DCS: begin
            res_valid = 1'b1;
            if (data_check == 8'd0) begin
               res.status       = ST_OK;
               res.frame_length = decl_len_ff;
            end else begin
               res.status = ST_DATA_CS;
            end
            phase_in = PH_DONE;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // An unfinished frame at the end of the window turns this item into an error
      // status, replacing any payload byte; the window end always clears the state.
      if (req_window_end) begin
         if (phase_in != PH_DONE) begin
            res_valid        = 1'b1;
            res.is_status    = 1'b1;
            res.payload_byte = '0;
            res.frame_length = '0;
            res.status       = (phase_in == PH_HUNT) ? ST_NO_START : ST_NO_DATA;
         end
         phase_in      = PH_HUNT;
         decl_len_in   = '0;
         bytes_left_in = '0;
         sum_in        = '0;
      end
   end

   // Result register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_drain) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept && res_valid) begin
         if (!out_valid_ff || out_drain) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_drain) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_drain) begin
            out_ff <= skid_ff;
         end
      end else if (req_accept && res_valid) begin
         if (!out_valid_ff || out_drain) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_status    = out_ff.is_status;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_status       = out_ff.status;
   assign rsp_frame_length = out_ff.frame_length;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the result register is empty");

   a_payload_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_status) |-> (rsp_status == ST_OK && rsp_frame_length == 8'd0))
      else $error("payload item carries status or length");

   a_window_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_window_end) |=> (phase_ff == PH_HUNT && sum_ff == 8'd0
                                          && bytes_left_ff == 8'd0))
      else $error("frame state not cleared after window end");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (bytes_left_ff != 8'd0))
      else $error("payload phase with no bytes left");

endmodule

### dv/response_frame_deframer_test.sv
// Self-checking testbench for the response frame deframer.
// Predicts each payload and status item from the bytes it feeds in and checks them in order.
// Depends on rfd_pkg and the response_frame_deframer RTL.
module response_frame_deframer_test
   import rfd_pkg::*;
();

   typedef logic [7:0] octet_list[$];

   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PHASE_BYTES = 200;
   localparam int MAX_PRINTED = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       req_window_end;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_status;
   logic [7:0] rsp_payload_byte;
   logic [2:0] rsp_status;
   logic [7:0] rsp_frame_length;

   // Predictor copy of the frame state and the length limit.
   phase_type  frame_phase;
   logic [7:0] length_field;
   logic [8:0] bytes_left;
   logic [7:0] data_sum;
   logic [7:0] max_payload_len;

   rsp_type pending_results[$];
   int      mismatches = 0;
   int      bytes_sent = 0;
   int      cycles = 0;

   // Idling controls for the sender and the receiver.
   bit       idle_enable = 1'b1;
   logic     stall_enable = 1'b1;
   logic     hold_toggle = 1'b0;
   logic     hold_seen = 1'b0;
   int       hold_count = 0;
   int       run_left = 0;

   response_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_window_end   (req_window_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_status    (rsp_is_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length)
   );

   always #5 clock = ~clock;

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      else if (pick < 92) return $urandom_range(1, 3);
      else return $urandom_range(4, 24);
   endfunction

   function automatic rsp_type status_item(status_type s, logic [7:0] len);
      rsp_type r;
      r.is_status = 1'b1;
      r.payload_byte = 8'h00;
      r.status = s;
      r.frame_length = len;
      return r;
   endfunction

   task automatic clear_frame_state();
      frame_phase = PH_HUNT;
      length_field = 8'h00;
      bytes_left = 9'd0;
      data_sum = 8'h00;
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic last);
      rsp_type    r;
      logic       have;
      logic [7:0] len_sum;
      have = 1'b0;
      r = status_item(ST_OK, 8'h00);
      case (frame_phase)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               frame_phase = PH_LEN;
            end else if (b != PAD_BYTE) begin
               r = status_item(ST_NO_START, 8'h00);
               have = 1'b1;
               frame_phase = PH_DONE;
            end
         end
         PH_LEN: begin
            length_field = b;
            frame_phase = PH_LCS;
         end
         PH_LCS: begin
            len_sum = length_field + b;
            if (len_sum != 8'h00) begin
               r = status_item(ST_LEN_CS, 8'h00);
               have = 1'b1;
               frame_phase = PH_DONE;
            end else if (length_field > max_payload_len) begin
               r = status_item(ST_TOO_LONG, 8'h00);
               have = 1'b1;
               frame_phase = PH_DONE;
            end else begin
               bytes_left = {1'b0, length_field};
               data_sum = 8'h00;
               frame_phase = (length_field == 8'h00) ? PH_DCS : PH_DATA;
            end
         end
         PH_DATA: begin
            data_sum = data_sum + b;
            r.is_status = 1'b0;
            r.payload_byte = b;
            have = 1'b1;
            if (bytes_left > 0) bytes_left = bytes_left - 9'd1;
            if (bytes_left == 0) frame_phase = PH_DCS;
         end
         PH_DCS: begin
            len_sum = data_sum + b;
            if (len_sum == 8'h00) r = status_item(ST_OK, length_field);
            else r = status_item(ST_DATA_CS, 8'h00);
            have = 1'b1;
            frame_phase = PH_DONE;
         end
         default: frame_phase = PH_DONE;
      endcase
      // An unfinished frame at the end of the window turns this byte's item into a status.
      if (last) begin
         if (frame_phase != PH_DONE) begin
            r = status_item((frame_phase == PH_HUNT) ? ST_NO_START : ST_NO_DATA, 8'h00);
            have = 1'b1;
         end
         clear_frame_state();
      end
      if (have) pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s: got %0d, expected %0d", cycles, what, got, want);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_enable ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_window_end <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      deframe_byte(b, last);
   endtask

   task automatic send_window(input octet_list w);
      for (int i = 0; i < w.size(); i++)
         send_byte(w[i], i == w.size() - 1);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_max_payload(input logic [7:0] v);
      wait_until_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_payload_len = v;
   endtask

   task automatic random_window(output octet_list w);
      int         len;
      int         pick;
      logic [7:0] b;
      logic [7:0] sum;
      w = {};
      if ($urandom_range(0, 99) < 20) begin
         // Noise: arbitrary bytes, which may or may not form the start of a frame.
         repeat ($urandom_range(1, 8)) begin
            b = 8'($urandom_range(0, 255));
            w.push_back(b);
         end
      end else begin
         repeat ($urandom_range(0, 3)) w.push_back(PAD_BYTE);
         w.push_back(START_BYTE);
         pick = $urandom_range(0, 99);
         if (pick < 70) len = $urandom_range(0, 8);
         else if (pick < 85) len = int'(max_payload_len) + $urandom_range(0, 2) - 1;
         else if (pick < 95) len = $urandom_range(9, 40);
         else len = $urandom_range(0, 255);
         if (len < 0) len = 0;
         if (len > 255) len = 255;
         b = 8'(256 - len);
         w.push_back(8'(len));
         if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
         w.push_back(b);
         sum = 8'h00;
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            w.push_back(b);
         end
         b = 8'h00 - sum;
         if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
         w.push_back(b);
         repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom_range(0, 255));
            w.push_back(b);
         end
         // Some windows end before the frame is complete.
         if ($urandom_range(0, 9) == 0) w = w[0:$urandom_range(0, w.size() - 1)];
      end
   endtask

   task automatic test_directed_frames();
      octet_list w;
      // Good frame after padding, payload extremes, then an ignored trailing byte.
      w = {PAD_BYTE, START_BYTE, 8'h02, 8'hFE, 8'h00, 8'hFF, 8'h01, 8'h77};
      send_window(w);
      // Empty payload closed by the window end on the checksum byte.
      w = {START_BYTE, 8'h00, 8'h00, 8'h00};
      send_window(w);
      // Bad start byte, rest of the window ignored.
      w = {8'h5A, 8'h00};
      send_window(w);
      // Length checksum wrong.
      w = {START_BYTE, 8'h03, 8'h00};
      send_window(w);
      // Data checksum wrong.
      w = {START_BYTE, 8'h01, 8'hFF, 8'h10, 8'h11};
      send_window(w);
      // Window holding only padding.
      w = {PAD_BYTE};
      send_window(w);
      // Window ends inside the payload.
      w = {START_BYTE, 8'h02, 8'hFE, 8'h33};
      send_window(w);
   endtask

   task automatic test_length_limits();
      octet_list  w;
      logic [7:0] b;
      logic [7:0] sum;
      set_max_payload(8'd1);
      w = {START_BYTE, 8'h01, 8'hFF, 8'h80, 8'h80};
      send_window(w);
      w = {START_BYTE, 8'h02, 8'hFE, 8'h00};
      send_window(w);
      // The length checksum is tested before the limit.
      w = {START_BYTE, 8'h05, 8'h00};
      send_window(w);
      set_max_payload(8'd255);
      w = {START_BYTE, 8'hFF, 8'h01};
      sum = 8'h00;
      repeat (255) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + b;
         w.push_back(b);
      end
      b = 8'h00 - sum;
      w.push_back(b);
      send_window(w);
      set_max_payload(8'd254);
      w = {START_BYTE, 8'hFF, 8'h01, 8'h00};
      send_window(w);
   endtask

   task automatic test_random_windows();
      octet_list w;
      int        start;
      logic [7:0] limit;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: limit = 8'd255;
            1: limit = 8'd1;
            default: limit = 8'($urandom_range(2, 254));
         endcase
         set_max_payload(limit);
         idle_enable = (p != 2);
         stall_enable <= (p != 2);
         // Hold the result side off while bytes keep coming, so the block backs up.
         if (p == 1) hold_toggle <= ~hold_toggle;
         start = bytes_sent;
         while (bytes_sent - start < RANDOM_PHASE_BYTES) begin
            random_window(w);
            send_window(w);
         end
      end
      idle_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_count <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_stall <= 1'b1;
      end else if (!stall_enable) begin
         rsp_stall <= 1'b0;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
      end else begin
         rsp_stall <= ~rsp_stall;
         run_left <= rsp_stall ? $urandom_range(0, 8) : idle_len();
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("item with none expected, status", rsp_status, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_is_status !== want.is_status)
               report_mismatch("is_status", rsp_is_status, want.is_status);
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_frame_length !== want.frame_length)
               report_mismatch("frame_length", rsp_frame_length, want.frame_length);
         end
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("response_frame_deframer_test NOT OK");
      $finish;
   end

   initial begin
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      req_window_end = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      clear_frame_state();
      max_payload_len = MAX_PAYLOAD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_length_limits();
      test_random_windows();
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("items never delivered", 0, pending_results.size());
      if (mismatches == 0) begin
         $display("response_frame_deframer_test OK");
      end else begin
         $display("response_frame_deframer_test NOT OK");
      end
      $finish;
   end

endmodule
